// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the echo spectrum block.
// Each macro samples on clk and is switched off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define PTE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent
`define PTE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// File: hw/rtl/pte_pkg.sv
// Shared types, constants and the CORDIC angle table for the echo spectrum block.
// No dependencies; every RTL module imports it.
package pte_pkg;

    localparam int NUM_BINS_DEF    = 64;
    localparam int SINCOS_BITS_DEF = 16;

    localparam int CORDIC_STEPS = 24;
    localparam int CW           = 34;   // CORDIC x/y width
    localparam int ZW           = 33;   // CORDIC angle width
    localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;

    localparam int ACC_W  = 48;
    localparam int PH_W   = 40;
    localparam int SQ_W   = 66;
    localparam int ROOT_W = SQ_W / 2;
    localparam int CS_W   = 17;
    localparam int PR_W   = 34;

    typedef enum logic [1:0] {
        REG_REF_RANGE = 2'd0,
        REG_CARRIER   = 2'd1,
        REG_BIN_RATE  = 2'd2,
        REG_NONE      = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic                 valid;
        logic                 flip;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
    } cordic_t;

    typedef struct packed {
        logic signed [ACC_W-1:0] re;
        logic signed [ACC_W-1:0] im;
    } acc_t;

    // arctan(2^-i) in turns, scaled by 2^32
    function automatic logic [31:0] atan_turn(input int idx);
        logic [31:0] v;
        unique case (idx)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

// File: hw/rtl/point_target_echo_spectrum.sv
// Point-target echo spectrum synthesizer: one reflector item at a time. An active
// item goes through squaring, a square root (start, 33 steps and done), the phase
// multiplies, the issue of NUM_BINS bins, one per cycle, into a 24-cell CORDIC chain,
// and a drain until the last bin is added into the ring. An inactive item that does
// not end the pulse leaves the block idle. A pulse-end item then emits NUM_BINS
// bins, one per cycle while m_tready stays high. The bins live in a ring of
// accumulator cells that advances once per bin update or per emitted bin.
// Depends on pte_pkg and the pte_isqrt, pte_cordic_cell and pte_acc_cell modules.
module point_target_echo_spectrum
    import pte_pkg::*;
#(
    parameter int NUM_BINS    = NUM_BINS_DEF,
    parameter int SINCOS_BITS = SINCOS_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    // plat_x, plat_y, plat_z, refl_x, refl_y, refl_z, amplitude, phase_bias
    input  logic [223:0] s_tdata,
    input  logic         s_tuser,   // active
    input  logic         s_tlast,   // pulse_end
    input  logic         s_tvalid,
    output logic         s_tready,
    // bin_index, real_part, imag_part, two zero pad bits
    output logic [103:0] m_tdata,
    output logic         m_tlast,   // last_bin
    output logic         m_tvalid,
    input  logic         m_tready,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    `include "assert_macros.svh"

    localparam int BW       = $clog2(NUM_BINS);
    localparam int CNT_W    = (BW > 3) ? BW : 3;
    localparam int HALF     = (NUM_BINS - 1) / 2;
    localparam int NEG_M    = NUM_BINS - 1 - HALF;
    localparam int SQ_LAST  = 2;
    localparam int MUL_LAST = 5;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SQ    = 7'b0000010,
        S_ROOT  = 7'b0000100,
        S_MUL   = 7'b0001000,
        S_BINS  = 7'b0010000,
        S_DRAIN = 7'b0100000,
        S_EMIT  = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [BW-1:0]     add_cnt_reg;
    logic              start_reg;
    logic              in_fire;

    logic [30:0]       ref_range_reg;
    logic [47:0]       carrier_reg;
    logic [39:0]       bin_rate_reg;
    logic              cfg_wr;
    reg_idx_t          cfg_idx;

    logic [31:0]       ax_reg, ay_reg, az_reg;
    logic [15:0]       amp_reg, offs_reg;
    logic              end_reg;
    logic [SQ_W-1:0]   sum_reg;
    logic [PH_W-1:0]   diff_reg, mul_acc_reg, p0_reg, d_reg, dm_reg, ph_reg;

    logic signed [32:0] dx, dy, dz;
    logic [31:0]       ax, ay, az;
    logic [31:0]       sq_op;
    logic [63:0]       sq;

    logic              sqrt_done;
    logic [ROOT_W-1:0] sqrt_root;

    logic [PH_W-1:0]   ma, mb40, part;
    logic [19:0]       mb;
    logic [59:0]       prod;

    logic [PH_W-1:0]   t;
    logic [31:0]       a32, a_adj;
    cordic_t           chain [0:CORDIC_STEPS];
    cordic_t           fin;
    logic signed [CW-1:0] xr, yr;
    logic signed [CS_W-1:0] c_raw, s_raw;
    logic              cs_valid_reg;
    logic signed [CS_W-1:0] c_reg, s_reg;
    logic              add_valid_reg;
    logic signed [PR_W-1:0] pr_re_reg, pr_im_reg;

    acc_t              ring [0:NUM_BINS-1];
    acc_t              tail_in;
    acc_t              head;
    logic              ring_shift;
    logic signed [ACC_W:0] sum_re, sum_im;
    logic [CNT_W+5:0]  cnt_ext;

    // Configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = reg_idx_t'(paddr[4:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_range_reg <= '0;
            carrier_reg   <= '0;
            bin_rate_reg  <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_REF_RANGE: ref_range_reg <= pwdata[30:0];
                REG_CARRIER:   carrier_reg   <= pwdata[47:0];
                REG_BIN_RATE:  bin_rate_reg  <= pwdata[39:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_REF_RANGE: prdata = {33'b0, ref_range_reg};
            REG_CARRIER:   prdata = {16'b0, carrier_reg};
            REG_BIN_RATE:  prdata = {24'b0, bin_rate_reg};
            default:       prdata = '0;
        endcase
    end

    // Input capture: absolute coordinate differences
    assign s_tready = (state_reg == S_IDLE);
    assign in_fire  = s_tvalid & s_tready;
    assign dx = $signed({s_tdata[31], s_tdata[31:0]})   - $signed({s_tdata[127], s_tdata[127:96]});
    assign dy = $signed({s_tdata[63], s_tdata[63:32]})  - $signed({s_tdata[159], s_tdata[159:128]});
    assign dz = $signed({s_tdata[95], s_tdata[95:64]})  - $signed({s_tdata[191], s_tdata[191:160]});
    assign ax = dx[32] ? 32'(-dx) : dx[31:0];
    assign ay = dy[32] ? 32'(-dy) : dy[31:0];
    assign az = dz[32] ? 32'(-dz) : dz[31:0];

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (in_fire)
                begin
                    if (s_tuser)
                        state_next = S_SQ;
                    else if (s_tlast)
                        state_next = S_EMIT;
                end
            end
            S_SQ:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(SQ_LAST))
                begin
                    state_next = S_ROOT;
                    cnt_next   = '0;
                end
            end
            S_ROOT:
            begin
                if (sqrt_done)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MUL_LAST))
                begin
                    state_next = S_BINS;
                    cnt_next   = '0;
                end
            end
            S_BINS:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_BINS - 1))
                begin
                    state_next = S_DRAIN;
                    cnt_next   = '0;
                end
            end
            S_DRAIN:
            begin
                if (add_valid_reg && add_cnt_reg == BW'(NUM_BINS - 1))
                    state_next = end_reg ? S_EMIT : S_IDLE;
            end
            S_EMIT:
            begin
                if (m_tready)
                begin
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(NUM_BINS - 1))
                    begin
                        state_next = S_IDLE;
                        cnt_next   = '0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            start_reg   <= 1'b0;
            add_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            start_reg <= (state_reg == S_SQ) && (cnt_reg == CNT_W'(SQ_LAST));
            if (in_fire)
                add_cnt_reg <= '0;
            else if (add_valid_reg)
                add_cnt_reg <= add_cnt_reg + 1'b1;
        end
    end

    // Sum of squares, one coordinate per cycle
    always_comb
    begin
        unique case (cnt_reg[1:0])
            2'd0:    sq_op = ax_reg;
            2'd1:    sq_op = ay_reg;
            default: sq_op = az_reg;
        endcase
    end
    assign sq = sq_op * sq_op;

    pte_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_reg),
        .radicand (sum_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // Phase multiplies modulo 2^40, split into two 40x20 halves
    always_comb
    begin
        ma = (cnt_reg[2:1] == 2'd2) ? d_reg : diff_reg;
        unique case (cnt_reg[2:1])
            2'd0:    mb40 = carrier_reg[39:0];
            2'd1:    mb40 = bin_rate_reg;
            default: mb40 = PH_W'(NEG_M);
        endcase
        mb   = cnt_reg[0] ? mb40[39:20] : mb40[19:0];
        prod = ma * mb;
        part = cnt_reg[0] ? (mul_acc_reg + {prod[19:0], 20'b0}) : prod[39:0];
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ax_reg   <= ax;
            ay_reg   <= ay;
            az_reg   <= az;
            amp_reg  <= s_tdata[207:192];
            offs_reg <= s_tdata[223:208];
            end_reg  <= s_tlast;
        end
        if (state_reg == S_SQ)
        begin
            if (cnt_reg == '0)
                sum_reg <= SQ_W'(sq);
            else
                sum_reg <= sum_reg + SQ_W'(sq);
        end
        if (sqrt_done)
            diff_reg <= PH_W'(sqrt_root) - PH_W'(ref_range_reg);
        if (state_reg == S_MUL)
        begin
            mul_acc_reg <= part;
            if (cnt_reg == CNT_W'(1))
                p0_reg <= part;
            if (cnt_reg == CNT_W'(3))
                d_reg <= part;
            if (cnt_reg == CNT_W'(MUL_LAST))
            begin
                dm_reg <= part;
                ph_reg <= p0_reg;
            end
        end
        if (state_reg == S_BINS)
        begin
            if (cnt_reg == CNT_W'(HALF))
                ph_reg <= p0_reg - dm_reg;
            else
                ph_reg <= ph_reg + d_reg;
        end
    end

    // Angle for the current bin, folded into the right half plane
    assign t     = {offs_reg, 24'b0} - ph_reg;
    assign a32   = {t[PH_W-1 -: SINCOS_BITS], {(32 - SINCOS_BITS){1'b0}}};
    assign a_adj = (a32[31] ^ a32[30]) ? {~a32[31], a32[30:0]} : a32;

    always_comb
    begin
        chain[0].valid = (state_reg == S_BINS);
        chain[0].flip  = a32[31] ^ a32[30];
        chain[0].x     = CORDIC_X0;
        chain[0].y     = '0;
        chain[0].z     = $signed({a_adj[31], a_adj});
    end

    for (genvar g = 0; g < CORDIC_STEPS; g++)
    begin : g_cordic
        pte_cordic_cell #(.STEP(g)) u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .din   (chain[g]),
            .dout  (chain[g+1])
        );
    end

    // Round, unfold, scale by amplitude
    assign fin   = chain[CORDIC_STEPS];
    assign xr    = (fin.x + CW'(16384)) >>> 15;
    assign yr    = (fin.y + CW'(16384)) >>> 15;
    assign c_raw = fin.flip ? -xr[CS_W-1:0] : xr[CS_W-1:0];
    assign s_raw = fin.flip ? -yr[CS_W-1:0] : yr[CS_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cs_valid_reg  <= 1'b0;
            add_valid_reg <= 1'b0;
        end
        else
        begin
            cs_valid_reg  <= fin.valid;
            add_valid_reg <= cs_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg     <= c_raw;
        s_reg     <= s_raw;
        pr_re_reg <= $signed({1'b0, amp_reg}) * c_reg;
        pr_im_reg <= $signed({1'b0, amp_reg}) * s_reg;
    end

    // Saturating add at the ring head; clear while emitting
    assign head   = ring[0];
    assign sum_re = $signed({head.re[ACC_W-1], head.re}) + (ACC_W+1)'(pr_re_reg);
    assign sum_im = $signed({head.im[ACC_W-1], head.im}) + (ACC_W+1)'(pr_im_reg);

    always_comb
    begin
        tail_in = '0;
        if (state_reg != S_EMIT)
        begin
            if (sum_re[ACC_W] != sum_re[ACC_W-1])
                tail_in.re = {sum_re[ACC_W], {(ACC_W-1){~sum_re[ACC_W]}}};
            else
                tail_in.re = sum_re[ACC_W-1:0];
            if (sum_im[ACC_W] != sum_im[ACC_W-1])
                tail_in.im = {sum_im[ACC_W], {(ACC_W-1){~sum_im[ACC_W]}}};
            else
                tail_in.im = sum_im[ACC_W-1:0];
        end
    end

    assign ring_shift = add_valid_reg | ((state_reg == S_EMIT) & m_tready);

    for (genvar i = 0; i < NUM_BINS; i++)
    begin : g_ring
        pte_acc_cell u_acc (
            .clk   (clk),
            .rst_n (rst_n),
            .shift (ring_shift),
            .din   ((i == NUM_BINS - 1) ? tail_in : ring[(i + 1) % NUM_BINS]),
            .dout  (ring[i])
        );
    end

    // Result stream straight from the ring head
    assign cnt_ext  = {6'b0, cnt_reg};
    assign m_tvalid = (state_reg == S_EMIT);
    assign m_tdata  = {2'b00, head.im, head.re, cnt_ext[5:0]};
    assign m_tlast  = (cnt_reg == CNT_W'(NUM_BINS - 1));

    `PTE_ASSERT_IMP(a_idle_quiet, s_tready, !m_tvalid && !add_valid_reg)
    `PTE_ASSERT_IMP(a_add_window, add_valid_reg, state_reg == S_BINS || state_reg == S_DRAIN)
    `PTE_ASSERT_IMP(a_root_window, sqrt_done, state_reg == S_ROOT)
    `PTE_ASSERT_NEXT(a_emit_done, m_tvalid && m_tready && m_tlast, s_tready)

endmodule

// File: hw/rtl/pte_isqrt.sv
// Iterative floor square root, two radicand bits per cycle.
// Depends on pte_pkg.
module pte_isqrt
    import pte_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SQ_W-1:0]   radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    localparam int ITERS = SQ_W / 2;
    localparam int IW    = $clog2(ITERS);
    localparam int RW    = ROOT_W + 2;

    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [IW-1:0]     cnt_reg, cnt_next;
    logic [SQ_W-1:0]   rad_reg, rad_next;
    logic [RW-1:0]     rem_reg, rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [RW+1:0]     rem_sh;
    logic [RW+1:0]     trial;

    // One restoring step per cycle
    always_comb
    begin
        rem_sh    = {rem_reg, rad_reg[SQ_W-1 -: 2]};
        trial     = {2'b00, root_reg, 2'b01};
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            run_next  = 1'b1;
            cnt_next  = '0;
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (run_reg)
        begin
            rad_next = {rad_reg[SQ_W-3:0], 2'b00};
            cnt_next = cnt_reg + 1'b1;
            if (rem_sh >= trial)
            begin
                rem_next  = RW'(rem_sh - trial);
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = RW'(rem_sh);
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            if (cnt_reg == IW'(ITERS - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// File: hw/rtl/pte_cordic_cell.sv
// One rotation cell of the pipelined CORDIC chain.
// Depends on pte_pkg.
module pte_cordic_cell
    import pte_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  cordic_t din,
    output cordic_t dout
);

    logic [31:0]          ang;
    logic signed [CW-1:0] xs;
    logic signed [CW-1:0] ys;
    cordic_t              cell_reg, cell_next;

    assign ang = atan_turn(STEP);
    assign xs  = din.x >>> STEP;
    assign ys  = din.y >>> STEP;

    // Rotate toward zero residual angle
    always_comb
    begin
        cell_next = din;
        if (din.z >= 0)
        begin
            cell_next.x = din.x - ys;
            cell_next.y = din.y + xs;
            cell_next.z = din.z - $signed({1'b0, ang});
        end
        else
        begin
            cell_next.x = din.x + ys;
            cell_next.y = din.y - xs;
            cell_next.z = din.z + $signed({1'b0, ang});
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_reg <= '0;
        end
        else
        begin
            cell_reg <= cell_next;
        end
    end

    assign dout = cell_reg;

endmodule

// File: hw/rtl/pte_acc_cell.sv
// One complex accumulator cell of the rotating bin ring.
// Depends on pte_pkg.
module pte_acc_cell
    import pte_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic shift,
    input  acc_t din,
    output acc_t dout
);

    acc_t val_reg;

    // Take the neighbor's value on every ring advance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            val_reg <= '0;
        end
        else if (shift)
        begin
            val_reg <= din;
        end
    end

    assign dout = val_reg;

endmodule

// File: sim/tb_point_target_echo_spectrum.sv
// Self-checking testbench for point_target_echo_spectrum: stream stimulus, APB setup,
// and a bit-exact spectrum predictor compared against every emitted bin.
// Depends on pte_pkg and the point_target_echo_spectrum RTL.
module tb_point_target_echo_spectrum;
    import pte_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BINS       = 64;
    localparam int PHASE_BITS = 16;
    localparam int DRAIN_WAIT = 400;
    localparam int IDLE_LIMIT = 20000;
    localparam longint SUM_MAX = 64'sd140737488355327;
    localparam longint SUM_MIN = -64'sd140737488355328;

    typedef struct {
        logic signed [31:0] px, py, pz, rx, ry, rz;
        logic [15:0]        amp;
        logic [15:0]        offs;
        logic               active;
        logic               pulse_end;
    } reflector_t;

    typedef struct {
        logic [5:0]  bin;
        logic [47:0] re;
        logic [47:0] im;
        logic        last;
    } bin_t;

    logic         clk;
    logic         rst_n;
    logic [223:0] s_tdata;
    logic         s_tuser;
    logic         s_tlast;
    logic         s_tvalid;
    logic         s_tready;
    logic [103:0] m_tdata;
    logic         m_tlast;
    logic         m_tvalid;
    logic         m_tready;
    logic         psel;
    logic         penable;
    logic         pwrite;
    logic [4:0]   paddr;
    logic [63:0]  pwdata;
    logic [63:0]  prdata;
    logic         pready;

    point_target_echo_spectrum dut (.*);

    // Arctangent of 2^-i in turns, scaled by 2^32
    localparam logic [31:0] ANGLE_STEP [24] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // Predictor state
    logic [30:0] center_range;
    logic [47:0] carrier_turns;
    logic [39:0] bin_turns;
    longint      sum_re [BINS];
    longint      sum_im [BINS];

    reflector_t  pending [$];
    bin_t        bins_due [$];
    reflector_t  cur;
    int          send_idle;
    int          recv_stall;
    int          errors;
    int          idle_cnt;

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic logic [32:0] range_root(logic [67:0] sq);
        logic [69:0] rem;
        logic [69:0] trial;
        logic [35:0] root;
        rem  = '0;
        root = '0;
        for (int i = 33; i >= 0; i--) begin
            rem   = (rem << 2) | 70'(sq[2*i+1 -: 2]);
            trial = (70'(root) << 2) | 70'd1;
            if (rem >= trial) begin
                rem  = rem - trial;
                root = (root << 1) | 36'd1;
            end else begin
                root = root << 1;
            end
        end
        return root[32:0];
    endfunction

    // Rotate-mode CORDIC over one turn; returns cos, sin near +-32768
    task automatic unit_phasor(input logic [31:0] ang, output longint c, output longint s);
        logic   flip;
        longint x, y, z, xs, ys;
        flip = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
        if (flip)
            ang = ang + 32'h80000000;
        x = 64'sd652032874;
        y = 0;
        z = longint'($signed(ang));
        for (int i = 0; i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys; y = y + xs; z = z - longint'(ANGLE_STEP[i]);
            end else begin
                x = x + ys; y = y - xs; z = z + longint'(ANGLE_STEP[i]);
            end
        end
        c = (x + 16384) >>> 15;
        s = (y + 16384) >>> 15;
        if (flip) begin
            c = -c;
            s = -s;
        end
    endtask

    function automatic longint clamp_add(longint a, longint b);
        longint r;
        r = a + b;
        if (r > SUM_MAX) return SUM_MAX;
        if (r < SUM_MIN) return SUM_MIN;
        return r;
    endfunction

    // Fold one accepted reflector into the spectrum; emit and clear on pulse end
    task automatic absorb_reflector(input reflector_t it);
        longint      dx, dy, dz, k, c, s;
        logic [67:0] ax, ay, az, sq;
        logic [63:0] diff, rate, prod;
        logic [39:0] t;
        logic [31:0] ang;
        bin_t        b;
        if (it.active) begin
            dx = longint'(it.px) - longint'(it.rx);
            dy = longint'(it.py) - longint'(it.ry);
            dz = longint'(it.pz) - longint'(it.rz);
            ax = 68'(dx < 0 ? -dx : dx);
            ay = 68'(dy < 0 ? -dy : dy);
            az = 68'(dz < 0 ? -dz : dz);
            sq = ax * ax + ay * ay + az * az;
            diff = 64'(range_root(sq)) - 64'(center_range);
            for (int n = 0; n < BINS; n++) begin
                k    = (n <= (BINS - 1) / 2) ? n : n - BINS;
                rate = 64'(carrier_turns) + 64'(k) * 64'(bin_turns);
                prod = diff * rate;
                t    = 40'(-prod) + {it.offs, 24'd0};
                ang  = 32'(t[39 -: PHASE_BITS]) << (32 - PHASE_BITS);
                unit_phasor(ang, c, s);
                sum_re[n] = clamp_add(sum_re[n], longint'(it.amp) * c);
                sum_im[n] = clamp_add(sum_im[n], longint'(it.amp) * s);
            end
        end
        if (it.pulse_end) begin
            for (int n = 0; n < BINS; n++) begin
                b.bin  = 6'(n);
                b.re   = sum_re[n][47:0];
                b.im   = sum_im[n][47:0];
                b.last = (n == BINS - 1);
                bins_due.push_back(b);
                sum_re[n] = 0;
                sum_im[n] = 0;
            end
        end
    endtask

    // Drive the slave side; absorb each accepted transaction
    always @(posedge clk) begin
        if (s_tvalid && s_tready)
            absorb_reflector(cur);
        if (!s_tvalid || s_tready) begin
            if (pending.size() > 0 && $urandom_range(99) >= send_idle) begin
                cur = pending.pop_front();
                s_tdata  <= {cur.offs, cur.amp, cur.rz, cur.ry, cur.rx, cur.pz, cur.py, cur.px};
                s_tuser  <= cur.active;
                s_tlast  <= cur.pulse_end;
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Check each emitted bin against the oldest expectation
    always @(posedge clk) begin
        bin_t want;
        if (m_tvalid && m_tready) begin
            if (bins_due.size() == 0) begin
                $error("unexpected bin transaction, bin_index %0d", m_tdata[5:0]);
                errors++;
            end else begin
                want = bins_due.pop_front();
                if (m_tdata[5:0] !== want.bin) begin
                    $error("bin_index exp %0d got %0d", want.bin, m_tdata[5:0]);
                    errors++;
                end
                if (m_tdata[53:6] !== want.re) begin
                    $error("real_part exp %h got %h", want.re, m_tdata[53:6]);
                    errors++;
                end
                if (m_tdata[101:54] !== want.im) begin
                    $error("imag_part exp %h got %h", want.im, m_tdata[101:54]);
                    errors++;
                end
                if (m_tlast !== want.last) begin
                    $error("last_bin exp %0d got %0d", want.last, m_tlast);
                    errors++;
                end
            end
        end
        m_tready <= ($urandom_range(99) >= recv_stall);
    end

    // Abort when nothing moves for too long
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt > IDLE_LIMIT) begin
            $display("tb_point_target_echo_spectrum failed");
            $finish;
        end
    end

    // Register write: setup then access; update the predictor with it
    task automatic reg_write(input reg_idx_t idx, input logic [63:0] val);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_REF_RANGE: center_range  = val[30:0];
            REG_CARRIER:   carrier_turns = val[47:0];
            REG_BIN_RATE:  bin_turns     = val[39:0];
            default: ;
        endcase
    endtask

    task automatic setup_regs(input logic [30:0] rr, input logic [47:0] cr,
                              input logic [39:0] br);
        // random junk above each register's width must be dropped
        reg_write(REG_REF_RANGE, {$urandom, 1'($urandom), rr});
        reg_write(REG_CARRIER, {16'($urandom), cr});
        reg_write(REG_BIN_RATE, {24'($urandom), br});
        reg_write(REG_NONE, {$urandom, $urandom});
    endtask

    function automatic reflector_t make_refl(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                             logic [31:0] rx, logic [31:0] ry, logic [31:0] rz,
                                             logic [15:0] amp, logic [15:0] offs,
                                             logic act, logic pend);
        reflector_t r;
        r.px = px; r.py = py; r.pz = pz;
        r.rx = rx; r.ry = ry; r.rz = rz;
        r.amp = amp; r.offs = offs;
        r.active = act; r.pulse_end = pend;
        return r;
    endfunction

    function automatic logic [31:0] near_coord();
        return 32'($signed($urandom_range(8388608)) - 32'sd4194304);
    endfunction

    function automatic reflector_t random_refl(logic pend);
        reflector_t r;
        if ($urandom_range(9) == 0)
            r = make_refl($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                          16'($urandom), 16'($urandom), 1'b1, pend);
        else
            r = make_refl(near_coord(), near_coord(), near_coord() + 32'd1000000,
                          near_coord(), near_coord(), near_coord(),
                          16'($urandom), 16'($urandom), 1'b1, pend);
        r.active = ($urandom_range(99) < 85);
        return r;
    endfunction

    // Queue random pulses of one to six reflectors, the last marking pulse end
    task automatic queue_pulses(input int count);
        int left, len;
        left = count;
        while (left > 0) begin
            len = $urandom_range(6, 1);
            if (len > left)
                len = left;
            for (int i = 0; i < len; i++)
                pending.push_back(random_refl(i == len - 1));
            left = left - len;
        end
    endtask

    // Hold until all queued work is accepted and every bin is back
    task automatic drain();
        while (pending.size() > 0 || s_tvalid || bins_due.size() > 0)
            @(negedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    initial begin
        rst_n = 1'b0;
        s_tdata = '0; s_tuser = 1'b0; s_tlast = 1'b0; s_tvalid = 1'b0;
        m_tready = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        errors = 0; idle_cnt = 0;
        send_idle = 0; recv_stall = 0;
        center_range = '0; carrier_turns = '0; bin_turns = '0;
        for (int n = 0; n < BINS; n++) begin
            sum_re[n] = 0;
            sum_im[n] = 0;
        end
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: extremes, zero range, inactive items, pulse boundaries
        setup_regs('1, '1, '1);
        pending.push_back(make_refl('0, '0, '0, '0, '0, '0, 16'hFFFF, 16'h0000, 1'b1, 1'b1));
        pending.push_back(make_refl(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                    32'h80000000, 32'h80000000, 32'h80000000,
                                    16'hFFFF, 16'hFFFF, 1'b1, 1'b0));
        pending.push_back(make_refl(32'h80000000, 32'h80000000, 32'h80000000,
                                    32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                    16'h0100, 16'h8000, 1'b1, 1'b0));
        pending.push_back(make_refl('1, '1, '1, '1, '1, '1, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0));
        pending.push_back(make_refl(32'd1000, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0,
                                    16'h0000, 16'h4000, 1'b1, 1'b1));
        pending.push_back(make_refl('1, '1, '1, '0, '0, '0, 16'hFFFF, 16'hC000, 1'b0, 1'b1));
        drain();

        setup_regs(31'd1000000, 48'd123456789, 40'd987654);
        pending.push_back(make_refl(32'd1000000, '0, '0, '0, '0, '0, 16'h0100, '0, 1'b1, 1'b0));
        pending.push_back(make_refl('0, 32'd1000000, '0, '0, '0, '0, 16'hFFFF, '1, 1'b1, 1'b0));
        pending.push_back(make_refl('0, '0, 32'hFFF00000, '0, '0, '0, 16'h8000, 16'h2000,
                                    1'b1, 1'b1));
        pending.push_back(make_refl(32'h55555555, 32'hAAAAAAAA, 32'h33333333,
                                    32'hCCCCCCCC, 32'h0F0F0F0F, 32'hF0F0F0F0,
                                    16'hAAAA, 16'h5555, 1'b1, 1'b1));
        drain();

        // Random phases with different flow control and register settings
        setup_regs(31'($urandom), 48'({$urandom, $urandom}), 40'({$urandom, $urandom}));
        send_idle = 0; recv_stall = 0;
        queue_pulses(75);
        drain();

        setup_regs(31'($urandom_range(2000000)), 48'($urandom) << 8, 40'($urandom) << 4);
        send_idle = 79; recv_stall = 0;
        queue_pulses(75);
        drain();

        setup_regs('0, '0, '0);
        send_idle = 0; recv_stall = 79;
        queue_pulses(75);
        drain();

        setup_regs(31'($urandom), 48'({$urandom, $urandom}), 40'({$urandom, $urandom}));
        send_idle = 12; recv_stall = 12;
        queue_pulses(75);
        drain();

        if (errors == 0)
            $display("tb_point_target_echo_spectrum passed");
        else
            $display("tb_point_target_echo_spectrum failed");
        $finish;
    end

endmodule
